FILE: hdl/assert_macros.svh
// assertion macros shared by the reply frame receiver rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rtl assertion failed");

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rtl assertion failed during reset");

`endif

FILE: hdl/rfr_pkg.sv
// types, constants and helpers for the reply frame receiver
// no dependencies
`default_nettype none

package rfr_pkg;

    localparam int unsigned POS_W      = 4;
    localparam int unsigned CAP_DEPTH  = 6;
    localparam int unsigned CAP_IDX_W  = 3;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_START   = 4'd0;
    localparam logic [POS_W-1:0] POS_VERSION = 4'd1;
    localparam logic [POS_W-1:0] POS_LENGTH  = 4'd2;
    localparam logic [POS_W-1:0] POS_COMMAND = 4'd3;
    localparam logic [POS_W-1:0] POS_FEEDBK  = 4'd4;
    localparam logic [POS_W-1:0] POS_DATA_HI = 4'd5;
    localparam logic [POS_W-1:0] POS_DATA_LO = 4'd6;
    localparam logic [POS_W-1:0] POS_CSUM_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_CSUM_LO = 4'd8;
    localparam logic [POS_W-1:0] POS_STOP    = 4'd9;

    // captured field slots
    localparam logic [CAP_IDX_W-1:0] CAP_COMMAND = 3'd2;
    localparam logic [CAP_IDX_W-1:0] CAP_FEEDBK  = 3'd3;
    localparam logic [CAP_IDX_W-1:0] CAP_DATA_HI = 3'd4;
    localparam logic [CAP_IDX_W-1:0] CAP_DATA_LO = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [1:0] CFG_START_SECOND = 2'd1;
    localparam logic [1:0] CFG_STOP_BYTE    = 2'd2;
    localparam logic [1:0] CFG_ERROR_CODE   = 2'd3;

    localparam logic [7:0] RST_START_FIRST  = 8'h7E;
    localparam logic [7:0] RST_START_SECOND = 8'hFF;
    localparam logic [7:0] RST_STOP_BYTE    = 8'hEF;
    localparam logic [7:0] RST_ERROR_CODE   = 8'h40;

    // error reply codes carried in data low
    localparam logic [7:0] ERR_REINIT_A = 8'h02;
    localparam logic [7:0] ERR_RESEND_A = 8'h03;
    localparam logic [7:0] ERR_RESEND_B = 8'h04;
    localparam logic [7:0] ERR_REINIT_B = 8'h05;
    localparam logic [7:0] ERR_REINIT_C = 8'h06;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RESEND = 2'd1;
    localparam logic [1:0] ACT_REINIT = 2'd2;

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] stop_byte;
        logic [7:0] error_code;
    } cfg_t;

    // last member lands in the lowest bits
    typedef struct packed {
        logic [1:0]  error_action;
        logic [15:0] reply_data;
        logic [7:0]  reply_feedback;
        logic [7:0]  reply_command;
        logic        checksum_ok;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [1:0] action_for(input logic [7:0] code);
        logic [1:0] act;
        act = ACT_NONE;
        if (code == ERR_RESEND_A || code == ERR_RESEND_B) begin
            act = ACT_RESEND;
        end else if (code == ERR_REINIT_A || code == ERR_REINIT_B ||
                     code == ERR_REINIT_C) begin
            act = ACT_REINIT;
        end
        return act;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/reply_frame_receiver_unit.sv
// reply frame receiver: the result of an accepted stop byte is registered before it reaches m_tvalid
// throughput one byte per cycle while s_tready is high; a two-deep output (result register plus skid)
// keeps s_tready high while one finished result waits on m_tready
// s_tready drops only when both output slots hold results
// aresetn (synchronous, active low) restores register defaults and frame position 0
`default_nettype none
`include "assert_macros.svh"

module reply_frame_receiver_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,  // rx_byte
    input  wire logic                      s_tuser,  // overrun
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // checksum_ok, reply_command, reply_feedback, reply_data, error_action, zero pad
    output logic [rfr_pkg::TDATA_W-1:0]    m_tdata,
    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_addr,
    input  wire logic [7:0]                cfg_wdata
);
    import rfr_pkg::*;

    cfg_t    cfg_reg;
    logic    in_acc, out_acc;
    logic    res_valid;
    result_t res;
    logic    m_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_first  <= RST_START_FIRST;
            cfg_reg.start_second <= RST_START_SECOND;
            cfg_reg.stop_byte    <= RST_STOP_BYTE;
            cfg_reg.error_code   <= RST_ERROR_CODE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_START_FIRST:  cfg_reg.start_first  <= cfg_wdata;
                CFG_START_SECOND: cfg_reg.start_second <= cfg_wdata;
                CFG_STOP_BYTE:    cfg_reg.stop_byte    <= cfg_wdata;
                CFG_ERROR_CODE:   cfg_reg.error_code   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_valid_reg && m_tready;

    rfr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (in_acc),
        .rx_byte    (s_tdata),
        .overrun    (s_tuser),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // no new item is taken while the skid slot is full
            if (out_acc) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (m_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (out_acc) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_acc) begin
                out_reg <= skid_reg;
            end
        end else if (res_valid) begin
            if (m_valid_reg && !m_tready) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, out_reg};

    `ASSERT_CLK(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> m_valid_reg)
    `ASSERT_CLK(a_action_needs_ok, aclk, aresetn,
        (m_valid_reg && out_reg.error_action != ACT_NONE) |-> out_reg.checksum_ok)
    `ASSERT_CLK(a_out_held_on_stall, aclk, aresetn,
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(out_reg)))

endmodule

`default_nettype wire

FILE: hdl/rfr_parser.sv
// frame position tracking, checksum and field capture for reply frames
// depends on rfr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rfr_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            byte_valid,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            overrun,
    input  wire rfr_pkg::cfg_t   cfg,
    output logic                 res_valid,
    output rfr_pkg::result_t     res
);
    import rfr_pkg::*;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [15:0]          sum_reg, sum_next;
    logic [7:0]           cap_reg [CAP_DEPTH];
    logic                 cap_we;
    logic [CAP_IDX_W-1:0] cap_idx;
    logic                 csum_zero;

    assign cap_idx = CAP_IDX_W'(pos_reg - POS_VERSION);
    assign csum_zero = (sum_reg == 16'd0);

    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        cap_we    = 1'b0;
        res_valid = 1'b0;
        res.checksum_ok    = csum_zero;
        res.reply_command  = cap_reg[CAP_COMMAND];
        res.reply_feedback = cap_reg[CAP_FEEDBK];
        res.reply_data     = {cap_reg[CAP_DATA_HI], cap_reg[CAP_DATA_LO]};
        res.error_action   = (csum_zero && cap_reg[CAP_COMMAND] == cfg.error_code)
                             ? action_for(cap_reg[CAP_DATA_LO]) : ACT_NONE;
        if (byte_valid) begin
            if (overrun) begin
                pos_next = POS_START;
                sum_next = 16'd0;
            end else begin
                case (pos_reg)
                    POS_START: begin
                        if (rx_byte == cfg.start_first) begin
                            pos_next = POS_VERSION;
                            sum_next = 16'd0;
                        end
                    end
                    POS_VERSION, POS_LENGTH, POS_COMMAND, POS_FEEDBK, POS_DATA_HI,
                    POS_DATA_LO: begin
                        // the second start byte doubles as the version byte
                        if (pos_reg == POS_VERSION && rx_byte != cfg.start_second) begin
                            pos_next = POS_START;
                        end else begin
                            cap_we   = 1'b1;
                            sum_next = sum_reg + {8'd0, rx_byte};
                            pos_next = pos_reg + POS_VERSION;
                        end
                    end
                    POS_CSUM_HI: begin
                        sum_next = sum_reg + {rx_byte, 8'd0};
                        pos_next = POS_CSUM_LO;
                    end
                    POS_CSUM_LO: begin
                        sum_next = sum_reg + {8'd0, rx_byte};
                        pos_next = POS_STOP;
                    end
                    POS_STOP: begin
                        res_valid = (rx_byte == cfg.stop_byte);
                        pos_next  = POS_START;
                    end
                    default: begin
                        pos_next = POS_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_START;
            sum_reg <= 16'd0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_we) begin
            cap_reg[cap_idx] <= rx_byte;
        end
    end

    `ASSERT_CLK(a_pos_in_frame, aclk, aresetn, pos_reg <= POS_STOP)
    `ASSERT_CLK(a_res_at_stop, aclk, aresetn, res_valid |-> pos_reg == POS_STOP)
    `ASSERT_CLK(a_overrun_no_res, aclk, aresetn, (byte_valid && overrun) |-> !res_valid)
    `ASSERT_ALWAYS(a_reset_pos, aclk, !aresetn |=> pos_reg == POS_START)

endmodule

`default_nettype wire
